// ===== rtl/hh4_pkg.sv =====
// shared types and constants for the hh4 integer nibble encoder
`default_nettype none
package hh4_pkg;

	// symbol geometry
	localparam int SYM_W    = 4;
	localparam int MAX_SYMS = 11;
	localparam int CODE_W   = SYM_W * MAX_SYMS;
	localparam int CNT_W    = 4;
	localparam int LEN_W    = 6;

	// encoding modes
	localparam logic ACT_UNSIGNED = 1'b0;
	localparam logic ACT_SIGNED   = 1'b1;

	// prefix symbols
	localparam logic [SYM_W-1:0] PFX_L6   = 4'h8;
	localparam logic [SYM_W-1:0] PFX_L9   = 4'hc;
	localparam logic [SYM_W-1:0] PFX_L12  = 4'he;
	localparam logic [SYM_W-1:0] PFX_LONG = 4'h7;
	localparam logic [SYM_W-1:0] PFX_EXT  = 4'h8;

	// data lengths in bits
	localparam logic [LEN_W-1:0] LEN_MIN = 6'd3;
	localparam logic [LEN_W-1:0] LEN_MAX = 6'd32;
	localparam int NUM_MID = 7;
	localparam logic [LEN_W-1:0] MID_LENS [NUM_MID] = '{
		6'd6, 6'd9, 6'd12, 6'd16, 6'd20, 6'd24, 6'd28
	};

	// complete code for one item, first symbol in the top nibble
	typedef struct packed {
		logic [CODE_W-1:0] syms;
		logic [CNT_W-1:0]  cnt;
	} code_t;

endpackage
`default_nettype wire

// ===== rtl/hh4_integer_nibble_encoder.sv =====
// top level of the hh4 integer nibble encoder
`default_nettype none
// Each item (action, value) becomes 1 to 11 nibbles, one per clock on nibble
// with strobe high and last marking the final nibble of the item. An item
// occupies the single output port until every nibble of its code is out
// (1 nibble for the 3-bit form, 10 for 28 bits and 11 for 32 bits), so the
// sustained rate is one nibble per cycle. The first nibble of an item passes
// the input register, the symbol shifter and the output register in turn. One
// item waits in the input register while the previous one is sent, and busy
// drops again in the cycle before the final nibble of that one appears on
// nibble, so items follow with no gap. The receiver cannot stall the output.
module hh4_integer_nibble_encoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output      logic        busy,
	input  wire logic        action,
	input  wire logic [31:0] value,
	output      logic        strobe,
	output      logic [3:0]  nibble,
	output      logic        last
);

	logic                             valid_s1;
	logic                             action_s1;
	logic [31:0]                      value_s1;
	hh4_pkg::code_t                   code;
	logic [hh4_pkg::CODE_W-1:0]       sh_q;
	logic [hh4_pkg::CNT_W-1:0]        rem_q;
	logic                             load;
	logic                             accept;

	// emitter takes a new code when idle or on its final nibble
	assign load   = valid_s1 && (rem_q <= 4'd1);
	assign busy   = valid_s1 && !load;
	assign accept = start && !busy;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			value_s1  <= value;
		end
	end

	hh4_code_build u_build (
		.action (action_s1),
		.value  (value_s1),
		.code   (code)
	);

	// symbol shifter and remaining count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= code.cnt;
		end else if (rem_q != '0) begin
			rem_q <= rem_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sh_q <= code.syms;
		end else begin
			sh_q <= {sh_q[hh4_pkg::CODE_W-5:0], 4'h0};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= (rem_q != '0);
		end
	end

	always_ff @(posedge clk) begin
		nibble <= sh_q[hh4_pkg::CODE_W-1 -: 4];
		last   <= (rem_q == 4'd1);
	end

	// remaining count never exceeds the longest code
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= 4'(hh4_pkg::MAX_SYMS))
		else $error("remaining symbol count out of range");

	// a loaded code has between one and eleven symbols
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (code.cnt >= 4'd1 && code.cnt <= 4'(hh4_pkg::MAX_SYMS)))
		else $error("code symbol count out of range");

	// an accepted item sits in the input register next cycle
	a_accept_held: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted item lost");

	// the final nibble of a code is followed by the next one only after a load
	a_last_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q == 4'd1 && !load) |=> (rem_q == '0))
		else $error("emitter count did not drain");

	// emitter reloads no earlier than the final nibble of the previous code
	a_load_safe: assert property (@(posedge clk) disable iff (!arst_n)
		(load && rem_q == 4'd1) |=> (strobe && last))
		else $error("code reloaded before its final nibble");

endmodule
`default_nettype wire

// ===== rtl/hh4_code_build.sv =====
// length choice and symbol layout for one item
`default_nettype none
module hh4_code_build (
	input  wire logic         action,
	input  wire logic [31:0]  value,
	output hh4_pkg::code_t    code
);

	logic [hh4_pkg::LEN_W-1:0] len;
	logic [hh4_pkg::SYM_W-1:0] pre [3];
	logic [1:0]                npre;
	logic [3:0]                ndata;

	// high-bit masks above a given length
	function automatic logic [31:0] hi_mask(input logic [hh4_pkg::LEN_W-1:0] l);
		logic [32:0] one_sh;
		one_sh = 33'd1 << l;
		return ~(one_sh[31:0] - 32'd1);
	endfunction

	// shortest length that holds the value; the 3-bit form excludes the pattern 111
	always_comb begin
		logic [31:0] m;
		logic [31:0] ms;
		len = hh4_pkg::LEN_MAX;
		for (int t = hh4_pkg::NUM_MID - 1; t >= 0; t--) begin
			m  = hi_mask(hh4_pkg::MID_LENS[t]);
			ms = hi_mask(hh4_pkg::MID_LENS[t] - 6'd1);
			if (action == hh4_pkg::ACT_SIGNED) begin
				if ((value & ms) == 32'd0 || (value & ms) == ms)
					len = hh4_pkg::MID_LENS[t];
			end else begin
				if ((value & m) == 32'd0)
					len = hh4_pkg::MID_LENS[t];
			end
		end
		if (action == hh4_pkg::ACT_SIGNED) begin
			if (((value & 32'hffff_fffc) == 32'd0 ||
				(value & 32'hffff_fffc) == 32'hffff_fffc) && value != 32'hffff_ffff)
				len = hh4_pkg::LEN_MIN;
		end else begin
			if (value[31])
				len = hh4_pkg::LEN_MAX;
			else if (value <= 32'd6)
				len = hh4_pkg::LEN_MIN;
		end
	end

	// prefix symbols and data count
	always_comb begin
		pre[0] = hh4_pkg::PFX_LONG;
		pre[1] = 4'(len >> 2);
		pre[2] = 4'(len >> 2);
		npre   = 2'd2;
		case (len)
			6'd3: begin
				pre[0] = {1'b0, value[2:0]};
				npre   = 2'd1;
			end
			6'd6: begin
				pre[0] = hh4_pkg::PFX_L6 | {2'b00, value[5:4]};
				npre   = 2'd1;
			end
			6'd9: begin
				pre[0] = hh4_pkg::PFX_L9 | {3'b000, value[8]};
				npre   = 2'd1;
			end
			6'd12: begin
				pre[0] = hh4_pkg::PFX_L12;
				npre   = 2'd1;
			end
			6'd28, 6'd32: begin
				pre[1] = hh4_pkg::PFX_EXT;
				npre   = 2'd3;
			end
			default: ;
		endcase
		ndata = 4'(len >> 2);
	end

	// lay out symbols, prefix first, then data nibbles from the top
	always_comb begin
		logic [3:0] k;
		logic [2:0] sel;
		code.syms = '0;
		for (int i = 0; i < hh4_pkg::MAX_SYMS; i++) begin
			k   = 4'(i) - {2'b00, npre};
			sel = 3'(ndata - 4'd1 - k);
			if (4'(i) < {2'b00, npre}) begin
				if (i < 3)
					code.syms[hh4_pkg::CODE_W-1-4*i -: 4] = pre[i];
			end else if (k < ndata) begin
				code.syms[hh4_pkg::CODE_W-1-4*i -: 4] = value[{sel, 2'b00} +: 4];
			end
		end
		code.cnt = {2'b00, npre} + ndata;
	end

endmodule
`default_nettype wire
